// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the mouse report encoder.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define MRE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define MRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mre_pkg.sv =====
// Package for the mouse report encoder: types, codes and constant tables.
// No dependencies; used by mouse_report_encoder.
package mre_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORTING_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY_MOTION        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SGR_ENCODING      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_INDICATOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_INDICATOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_INDICATOR   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_REPORT      = 2'd0;
    localparam logic [1:0] ST_CONSUMED    = 2'd1;
    localparam logic [1:0] ST_NOT_HANDLED = 2'd2;

    // Button codes
    localparam logic [6:0] BTN_LEFT       = 7'h00;
    localparam logic [6:0] BTN_MIDDLE     = 7'h01;
    localparam logic [6:0] BTN_RIGHT      = 7'h02;
    localparam logic [6:0] BTN_NONE       = 7'h03;
    localparam logic [6:0] BTN_WHEEL_UP   = 7'h40;
    localparam logic [6:0] BTN_WHEEL_DOWN = 7'h41;
    localparam logic [7:0] MOTION_BIT     = 8'h20;

    // X10 coordinate limit and offsets
    localparam logic [14:0] X10_LIMIT  = 15'd222;
    localparam logic [7:0]  X10_OFFSET = 8'd32;   // applied on top of position+1

    // Report characters
    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;   // '['
    localparam logic [7:0] CH_LT      = 8'h3c;   // '<'
    localparam logic [7:0] CH_SEMI    = 8'h3b;   // ';'
    localparam logic [7:0] CH_ZERO    = 8'h30;   // '0'
    localparam logic [7:0] CH_UPPER_M = 8'h4d;   // 'M'
    localparam logic [7:0] CH_LOWER_M = 8'h6d;   // 'm'

    // Byte sequencer segments
    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_STATUS,
        SEG_ESC,
        SEG_BRACKET,
        SEG_INTRO,
        SEG_CODE,
        SEG_SEMI_X,
        SEG_X,
        SEG_SEMI_Y,
        SEG_Y,
        SEG_FINAL,
        SEG_X10_CODE,
        SEG_X10_X,
        SEG_X10_Y
    } t_seg;

    // Decimal digit thresholds: DEC_STEP[k][j] = j * 10**k
    localparam int unsigned DEC_W = 17;
    localparam logic [DEC_W-1:0] DEC_STEP [5][10] = '{
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
          17'd90},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
          17'd800, 17'd900},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
          17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000,
          17'd70000, 17'd80000, 17'd90000}
    };

    // Power of ten of the leading decimal digit (digit count minus one)
    function automatic logic [2:0] mre_lead_pow(input logic [15:0] v);
        logic [2:0] p;
        if (v >= 16'd10000)     p = 3'd4;
        else if (v >= 16'd1000) p = 3'd3;
        else if (v >= 16'd100)  p = 3'd2;
        else if (v >= 16'd10)   p = 3'd1;
        else                    p = 3'd0;
        return p;
    endfunction

endpackage

// ===== rtl/core/mouse_report_encoder.sv =====
// Mouse report encoder top level: event input register, report byte sequencer
// and output register. Depends on mre_pkg and assert_macros.svh.

// An accepted mouse event yields one result per cycle while the output is not
// stalled: a single result for a status-only event (not handled or consumed),
// 6 bytes for an X10 report and 9 to 19 bytes for an SGR report. The byte
// sequencer sends one byte a cycle while the output is not stalled and works
// out each decimal digit as it goes. One further event waits in the input
// register while a report is being sent and is taken up by the sequencer as
// the previous last byte is sent, so reports follow with no gap when unstalled.
`include "assert_macros.svh"

module mouse_report_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Event channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_left_pressed,
    input  logic                              i_middle_pressed,
    input  logic                              i_right_pressed,
    input  logic                              i_wheeled,
    input  logic signed [15:0]                i_wheel_delta,
    input  logic                              i_moved,
    input  logic                              i_ctrl_held,
    input  logic                              i_alt_held,
    input  logic                              i_shift_held,
    input  logic [14:0]                       i_pos_x,
    input  logic [14:0]                       i_pos_y,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_out_byte,
    output logic [1:0]                        o_status,
    output logic                              o_last_of_run,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);

    import mre_pkg::*;

    // Configuration registers
    logic       r_cfg_enabled;
    logic       r_cfg_any_motion;
    logic       r_cfg_sgr;
    logic [7:0] r_cfg_ctrl_ind;
    logic [7:0] r_cfg_alt_ind;

    // Input register
    logic        r_in_valid;
    logic        r_left, r_middle, r_right, r_wheeled, r_moved;
    logic        r_ctrl, r_alt, r_shift;
    logic [15:0] r_delta;
    logic [14:0] r_pos_x, r_pos_y;

    // Remembered button code
    logic [6:0] r_prev;
    logic [6:0] n_prev;

    // Sequencer job registers
    t_seg        r_seg, n_seg;
    logic [7:0]  r_code;
    logic [15:0] r_x1, r_y1;
    logic        r_press;
    logic        r_sgr;
    logic [1:0]  r_status;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_pow, n_pow;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [1:0] r_out_status;
    logic       r_out_last;

    // Event decode results
    logic       j_reject, j_none, j_consume, j_up, j_use_prev, j_far;
    logic [6:0] j_base, j_code7;
    logic [7:0] j_code;
    logic [1:0] j_status;
    logic       j_status_only;

    // Handshake and sequencing controls
    logic       out_free, advance, seg_last, last_emit, job_take, in_take;
    logic [7:0] seg_byte;

    // Digit extraction
    logic [3:0]       dig;
    logic [DEC_W-1:0] dig_sub;

    // Accept configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enabled    <= 1'b0;
            r_cfg_any_motion <= 1'b0;
            r_cfg_sgr        <= 1'b0;
            r_cfg_ctrl_ind   <= 8'd16;
            r_cfg_alt_ind    <= 8'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REPORTING_ENABLED: r_cfg_enabled    <= i_cfg_data[0];
                CFG_ANY_MOTION:        r_cfg_any_motion <= i_cfg_data[0];
                CFG_SGR_ENCODING:      r_cfg_sgr        <= i_cfg_data[0];
                CFG_CTRL_INDICATOR:    r_cfg_ctrl_ind   <= i_cfg_data;
                CFG_ALT_INDICATOR:     r_cfg_alt_ind    <= i_cfg_data;
                // Shift events are rejected before a code is formed, so the
                // shift indicator never reaches a report: drop the write.
                CFG_SHIFT_INDICATOR:   ;
                default:               ;
            endcase
        end
    end

    // Output register takes a byte when empty or being drained
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = (r_seg != SEG_IDLE) && out_free;
    assign last_emit = advance && seg_last;
    assign job_take  = r_in_valid && ((r_seg == SEG_IDLE) || last_emit);
    assign o_in_stall = r_in_valid && !job_take;
    assign in_take    = i_in_valid && !o_in_stall;

    // Hold the waiting event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (job_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_left    <= i_left_pressed;
            r_middle  <= i_middle_pressed;
            r_right   <= i_right_pressed;
            r_wheeled <= i_wheeled;
            r_delta   <= i_wheel_delta;
            r_moved   <= i_moved;
            r_ctrl    <= i_ctrl_held;
            r_alt     <= i_alt_held;
            r_shift   <= i_shift_held;
            r_pos_x   <= i_pos_x;
            r_pos_y   <= i_pos_y;
        end
    end

    // Form the button code and classify the event
    always_comb begin
        j_reject  = r_shift || !r_cfg_enabled;
        j_none    = !r_left && !r_middle && !r_right && !r_wheeled;
        j_consume = r_moved && j_none && !r_cfg_any_motion;
        j_up      = !r_delta[15] && (r_delta != 16'd0);

        if (r_wheeled)     j_base = j_up ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
        else if (r_right)  j_base = BTN_RIGHT;
        else if (r_middle) j_base = BTN_MIDDLE;
        else if (r_left)   j_base = BTN_LEFT;
        else               j_base = BTN_NONE;

        // A release in SGR mode reuses the remembered code and clears it
        j_use_prev = j_none && r_cfg_sgr && (r_prev != 7'd0);
        j_code7    = j_use_prev ? r_prev : j_base;
        n_prev     = j_use_prev ? 7'd0 : j_base;

        j_code = {1'b0, j_code7};
        if (r_moved) j_code = j_code | MOTION_BIT;
        if (r_ctrl)  j_code = j_code | r_cfg_ctrl_ind;
        if (r_alt)   j_code = j_code | r_cfg_alt_ind;

        j_far = !r_cfg_sgr && ((r_pos_x >= X10_LIMIT) || (r_pos_y >= X10_LIMIT));

        if (j_reject)               j_status = ST_NOT_HANDLED;
        else if (j_consume || j_far) j_status = ST_CONSUMED;
        else                        j_status = ST_REPORT;
        j_status_only = (j_status != ST_REPORT);
    end

    // Remember the base code of every formed code, or clear it when a release reuses it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 7'd0;
        end else if (job_take && !j_reject && !j_consume) begin
            r_prev <= n_prev;
        end
    end

    // Load the job for the sequencer
    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_code   <= j_code;
            r_x1     <= {1'b0, r_pos_x} + 16'd1;
            r_y1     <= {1'b0, r_pos_y} + 16'd1;
            r_press  <= !j_none;
            r_sgr    <= r_cfg_sgr;
            r_status <= j_status;
        end
    end

    // Pick the current decimal digit by comparing against its multiples
    always_comb begin
        dig     = 4'd0;
        dig_sub = '0;
        for (int j = 1; j < 10; j++) begin
            if ({1'b0, r_rem} >= DEC_STEP[r_pow][j]) begin
                dig     = 4'(j);
                dig_sub = DEC_STEP[r_pow][j];
            end
        end
    end

    // Sequencer next state
    always_comb begin
        n_seg = r_seg;
        n_rem = r_rem;
        n_pow = r_pow;
        if (advance) begin
            case (r_seg)
                SEG_STATUS:  n_seg = SEG_IDLE;
                SEG_ESC:     n_seg = SEG_BRACKET;
                SEG_BRACKET: n_seg = SEG_INTRO;
                SEG_INTRO: begin
                    if (r_sgr) begin
                        n_seg = SEG_CODE;
                        n_rem = {8'd0, r_code};
                        n_pow = mre_lead_pow({8'd0, r_code});
                    end else begin
                        n_seg = SEG_X10_CODE;
                    end
                end
                SEG_CODE, SEG_X, SEG_Y: begin
                    n_rem = 16'({1'b0, r_rem} - dig_sub);
                    n_pow = r_pow - 3'd1;
                    if (r_pow == 3'd0) begin
                        case (r_seg)
                            SEG_CODE: n_seg = SEG_SEMI_X;
                            SEG_X:    n_seg = SEG_SEMI_Y;
                            default:  n_seg = SEG_FINAL;
                        endcase
                    end
                end
                SEG_SEMI_X: begin
                    n_seg = SEG_X;
                    n_rem = r_x1;
                    n_pow = mre_lead_pow(r_x1);
                end
                SEG_SEMI_Y: begin
                    n_seg = SEG_Y;
                    n_rem = r_y1;
                    n_pow = mre_lead_pow(r_y1);
                end
                SEG_FINAL:    n_seg = SEG_IDLE;
                SEG_X10_CODE: n_seg = SEG_X10_X;
                SEG_X10_X:    n_seg = SEG_X10_Y;
                SEG_X10_Y:    n_seg = SEG_IDLE;
                default:      n_seg = SEG_IDLE;
            endcase
        end
        // Start the waiting event as soon as the previous one is done
        if (job_take) begin
            n_seg = j_status_only ? SEG_STATUS : SEG_ESC;
        end
    end

    // Sequencer outputs: byte of the current segment and end of run
    always_comb begin
        seg_byte = 8'd0;
        seg_last = 1'b0;
        case (r_seg)
            SEG_STATUS:   seg_last = 1'b1;
            SEG_ESC:      seg_byte = CH_ESC;
            SEG_BRACKET:  seg_byte = CH_BRACKET;
            SEG_INTRO:    seg_byte = r_sgr ? CH_LT : CH_UPPER_M;
            SEG_CODE, SEG_X, SEG_Y:
                          seg_byte = CH_ZERO | {4'd0, dig};
            SEG_SEMI_X, SEG_SEMI_Y:
                          seg_byte = CH_SEMI;
            SEG_FINAL: begin
                seg_byte = r_press ? CH_UPPER_M : CH_LOWER_M;
                seg_last = 1'b1;
            end
            SEG_X10_CODE: seg_byte = r_code | MOTION_BIT;
            SEG_X10_X:    seg_byte = r_x1[7:0] + X10_OFFSET;
            SEG_X10_Y: begin
                seg_byte = r_y1[7:0] + X10_OFFSET;
                seg_last = 1'b1;
            end
            default:      seg_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_IDLE;
        end else begin
            r_seg <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_pow <= n_pow;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= seg_byte;
            r_out_status <= (r_seg == SEG_STATUS) ? r_status : ST_REPORT;
            r_out_last   <= seg_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

    // A status-only result carries no byte and ends its run
    `MRE_ASSERT_ALWAYS(a_status_single,
        !(o_out_valid && (o_status != ST_REPORT)) || (o_last_of_run && (o_out_byte == 8'd0)),
        "status result without last flag or with nonzero byte")

    // The remainder in a number segment stays below ten times the digit weight
    `MRE_ASSERT_ALWAYS(a_rem_bound,
        !((r_seg == SEG_CODE) || (r_seg == SEG_X) || (r_seg == SEG_Y)) ||
        ((r_pow <= 3'd4) && (dig != 4'd9 || ({1'b0, r_rem} - dig_sub) < DEC_STEP[r_pow][1])),
        "decimal remainder out of range for current digit")

    // Finishing a run with no waiting event leaves the sequencer idle
    `MRE_ASSERT_NEXT(a_idle_after_last, last_emit && !job_take, r_seg == SEG_IDLE,
        "sequencer not idle after last byte")

    // A waiting event that is held back is kept
    `MRE_ASSERT_NEXT(a_in_held, r_in_valid && !job_take, r_in_valid,
        "waiting event lost")

endmodule

// ===== dv/mouse_report_encoder_tb.sv =====
// Testbench for mouse_report_encoder: sends mouse event transactions and checks every
// report byte against a scoreboard that predicts the X10 and SGR encodings.
// Depends on mre_pkg and the mouse_report_encoder RTL.
module mouse_report_encoder_tb;
    import mre_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam logic [7:0]  X10_BIAS     = 8'd33;

    typedef struct {
        logic               left;
        logic               middle;
        logic               right;
        logic               wheeled;
        logic signed [15:0] delta;
        logic               moved;
        logic               ctrl;
        logic               alt;
        logic               shift;
        logic [14:0]        px;
        logic [14:0]        py;
    } t_mouse_evt;

    typedef struct {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_report_byte;

    // Scoreboard: predicts the report bytes of each event and checks the output
    class report_scoreboard;
        logic         rep_en     = 1'b0;
        logic         any_motion = 1'b0;
        logic         sgr_mode   = 1'b0;
        logic [7:0]   ctrl_bits  = 8'd16;
        logic [7:0]   alt_bits   = 8'd8;
        logic [7:0]   shift_bits = 8'd4;
        logic [6:0]   last_button = 7'd0;
        t_report_byte expected_bytes[$];
        int unsigned  errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_REPORTING_ENABLED: rep_en     = val[0];
                CFG_ANY_MOTION:        any_motion = val[0];
                CFG_SGR_ENCODING:      sgr_mode   = val[0];
                CFG_CTRL_INDICATOR:    ctrl_bits  = val;
                CFG_ALT_INDICATOR:     alt_bits   = val;
                CFG_SHIFT_INDICATOR:   shift_bits = val;
                default: ;
            endcase
        endfunction

        function void add_byte(logic [7:0] data, logic [1:0] status, logic last);
            t_report_byte b;
            b.data   = data;
            b.status = status;
            b.last   = last;
            expected_bytes.push_back(b);
        endfunction

        // Work out the byte sequence of one accepted event transaction
        function void note_event(t_mouse_evt e);
            logic       idle_btns;
            logic [7:0] code;
            logic [7:0] seq[$];
            string      s;
            if (e.shift || !rep_en) begin
                add_byte(8'd0, ST_NOT_HANDLED, 1'b1);
                return;
            end
            idle_btns = !(e.left || e.middle || e.right || e.wheeled);
            if (e.moved && idle_btns && !any_motion) begin
                add_byte(8'd0, ST_CONSUMED, 1'b1);
                return;
            end

            // Right wins over middle, middle over left, wheel over all
            code = {1'b0, BTN_NONE};
            if (e.left)    code = {1'b0, BTN_LEFT};
            if (e.middle)  code = {1'b0, BTN_MIDDLE};
            if (e.right)   code = {1'b0, BTN_RIGHT};
            if (e.wheeled) code = (e.delta > 0) ? {1'b0, BTN_WHEEL_UP} : {1'b0, BTN_WHEEL_DOWN};

            // SGR release reuses the remembered button once; left counts as none
            if (idle_btns && sgr_mode && last_button != 7'd0) begin
                code = {1'b0, last_button};
                last_button = 7'd0;
            end else begin
                last_button = code[6:0];
            end

            if (e.moved) code = code | MOTION_BIT;
            if (e.ctrl)  code = code | ctrl_bits;
            if (e.alt)   code = code | alt_bits;

            if (sgr_mode) begin
                s = $sformatf("[<%0d;%0d;%0d", code, int'(e.px) + 1, int'(e.py) + 1);
                seq.push_back(CH_ESC);
                for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
                seq.push_back(idle_btns ? CH_LOWER_M : CH_UPPER_M);
            end else begin
                if (e.px >= X10_LIMIT || e.py >= X10_LIMIT) begin
                    add_byte(8'd0, ST_CONSUMED, 1'b1);
                    return;
                end
                seq.push_back(CH_ESC);
                seq.push_back(CH_BRACKET);
                seq.push_back(CH_UPPER_M);
                seq.push_back(code | MOTION_BIT);
                seq.push_back(e.px[7:0] + X10_BIAS);
                seq.push_back(e.py[7:0] + X10_BIAS);
            end
            foreach (seq[i]) add_byte(seq[i], ST_REPORT, i == seq.size() - 1);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_byte(logic [7:0] data, logic [1:0] status, logic last);
            t_report_byte want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: result byte %02h status %0d last %0b with no event pending",
                         $time, data, status, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic                 i_left_pressed   = 1'b0;
    logic                 i_middle_pressed = 1'b0;
    logic                 i_right_pressed  = 1'b0;
    logic                 i_wheeled        = 1'b0;
    logic signed [15:0]   i_wheel_delta    = '0;
    logic                 i_moved          = 1'b0;
    logic                 i_ctrl_held      = 1'b0;
    logic                 i_alt_held       = 1'b0;
    logic                 i_shift_held     = 1'b0;
    logic [14:0]          i_pos_x          = '0;
    logic [14:0]          i_pos_y          = '0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic [7:0]           o_out_byte;
    logic [1:0]           o_status;
    logic                 o_last_of_run;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [7:0]           i_cfg_data       = '0;

    int unsigned      tx_idle_pct = 7;
    int unsigned      rx_idle_pct = 85;
    int unsigned      rx_hold_req = 0;
    report_scoreboard board;

    mouse_report_encoder dut (.*);

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("** mouse_report_encoder: FAILED **");
        $finish;
    end

    // Receive results: check each transaction, stall at random or hold off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                board.check_byte(o_out_byte, o_status, o_last_of_run);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic t_mouse_evt make_evt(logic left, logic middle, logic right,
                                            logic wheeled, logic signed [15:0] delta,
                                            logic moved, logic ctrl, logic alt,
                                            logic shift, logic [14:0] px,
                                            logic [14:0] py);
        t_mouse_evt e;
        e.left    = left;
        e.middle  = middle;
        e.right   = right;
        e.wheeled = wheeled;
        e.delta   = delta;
        e.moved   = moved;
        e.ctrl    = ctrl;
        e.alt     = alt;
        e.shift   = shift;
        e.px      = px;
        e.py      = py;
        return e;
    endfunction

    function automatic t_mouse_evt random_event();
        t_mouse_evt e;
        e = make_evt(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Mostly one button or none, sometimes any mix
        case ($urandom_range(5))
            0: e.left    = 1'b1;
            1: e.middle  = 1'b1;
            2: e.right   = 1'b1;
            3: e.wheeled = 1'b1;
            4: {e.left, e.middle, e.right, e.wheeled} = 4'($urandom_range(15));
            default: ;
        endcase
        case ($urandom_range(7))
            0: e.delta = 16'sh7fff;
            1: e.delta = 16'sh8000;
            2: e.delta = 16'sh0000;
            3: e.delta = 16'sh0001;
            4: e.delta = -16'sh0001;
            default: e.delta = 16'($urandom);
        endcase
        e.moved = 1'($urandom_range(1));
        e.ctrl  = 1'($urandom_range(1));
        e.alt   = 1'($urandom_range(1));
        e.shift = ($urandom_range(9) == 0);
        // Cover the X10 edge, small, mid and full-range positions
        case ($urandom_range(3))
            0: begin
                e.px = 15'($urandom);
                e.py = 15'($urandom);
            end
            1: begin
                e.px = 15'($urandom_range(221));
                e.py = 15'($urandom_range(221));
            end
            2: begin
                e.px = 15'($urandom_range(225, 218));
                e.py = 15'($urandom_range(225, 218));
            end
            default: begin
                e.px = 15'($urandom_range(15));
                e.py = 15'($urandom_range(15));
            end
        endcase
        return e;
    endfunction

    // Offer one event transaction and wait until the block takes it
    task automatic send_event(input t_mouse_evt e);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_left_pressed   <= e.left;
        i_middle_pressed <= e.middle;
        i_right_pressed  <= e.right;
        i_wheeled        <= e.wheeled;
        i_wheel_delta    <= e.delta;
        i_moved          <= e.moved;
        i_ctrl_held      <= e.ctrl;
        i_alt_held       <= e.alt;
        i_shift_held     <= e.shift;
        i_pos_x          <= e.px;
        i_pos_y          <= e.py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_event(e);
    endtask

    // Drop valid and hold until every predicted byte has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays up so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic write_all(input logic en, input logic any, input logic sgr,
                             input logic [7:0] ctrl, input logic [7:0] alt,
                             input logic [7:0] shift);
        write_reg(CFG_REPORTING_ENABLED, {7'd0, en});
        write_reg(CFG_ANY_MOTION, {7'd0, any});
        write_reg(CFG_SGR_ENCODING, {7'd0, sgr});
        write_reg(CFG_CTRL_INDICATOR, ctrl);
        write_reg(CFG_ALT_INDICATOR, alt);
        write_reg(CFG_SHIFT_INDICATOR, shift);
        i_cfg_valid <= 1'b0;
    endtask

    // Random press/release sequences, with optional hold-off and mid-phase pause
    task automatic run_random(input int unsigned n_items, input bit hold_rx,
                              input bit mid_pause);
        t_mouse_evt  e;
        int unsigned sent;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        if (hold_rx) rx_hold_req = HOLD_CYCLES;
        while (sent < n_items) begin
            if (mid_pause && !paused && sent >= n_items / 2) begin
                settle();
                paused = 1'b1;
            end
            e = random_event();
            send_event(e);
            sent++;
            if ((e.left || e.middle || e.right || e.wheeled) && $urandom_range(1)) begin
                e.left    = 1'b0;
                e.middle  = 1'b0;
                e.right   = 1'b0;
                e.wheeled = 1'b0;
                e.moved   = 1'($urandom_range(1));
                e.shift   = ($urandom_range(15) == 0);
                send_event(e);
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        board = new;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: reporting off
        send_event(make_evt(1, 0, 0, 0, 0, 0, 0, 0, 0, 5, 5));
        settle();

        // X10 with reset indicators
        write_reg(CFG_REPORTING_ENABLED, 8'd1);
        i_cfg_valid <= 1'b0;
        send_event(make_evt(1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        send_event(make_evt(0, 1, 0, 0, 0, 1, 0, 0, 0, 221, 221));
        send_event(make_evt(0, 0, 1, 0, 0, 0, 0, 0, 0, 222, 0));
        send_event(make_evt(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 222));
        send_event(make_evt(0, 0, 0, 0, 0, 1, 0, 0, 0, 7, 7));
        send_event(make_evt(1, 0, 0, 0, 0, 0, 0, 0, 1, 7, 7));
        send_event(make_evt(0, 0, 0, 1, 16'sh0001, 0, 0, 0, 0, 10, 10));
        send_event(make_evt(0, 0, 0, 1, 16'sh0000, 0, 0, 0, 0, 10, 10));
        send_event(make_evt(0, 0, 0, 1, 16'sh8000, 1, 0, 0, 0, 10, 10));
        send_event(make_evt(0, 0, 0, 1, 16'sh7fff, 0, 0, 0, 0, 10, 10));
        send_event(make_evt(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 4));
        settle();

        // SGR with any-motion, full ctrl and shift indicators, a zero alt indicator and the longest report
        write_all(1'b1, 1'b1, 1'b1, 8'hff, 8'h00, 8'hff);
        send_event(make_evt(1, 0, 0, 0, 0, 0, 1, 0, 0, 15'h7fff, 15'h7fff));
        send_event(make_evt(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_event(make_evt(0, 0, 1, 0, 0, 0, 0, 0, 0, 9, 99));
        send_event(make_evt(0, 0, 0, 0, 0, 0, 0, 0, 0, 9, 99));
        send_event(make_evt(0, 0, 0, 0, 0, 1, 0, 0, 0, 9, 99));
        send_event(make_evt(0, 0, 0, 1, -16'sh0005, 0, 0, 1, 0, 0, 0));
        send_event(make_evt(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        send_event(make_evt(1, 1, 1, 0, 0, 0, 0, 0, 0, 999, 9999));
        send_event(make_evt(0, 1, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        settle();

        // Reporting off again
        write_reg(CFG_REPORTING_ENABLED, 8'd0);
        i_cfg_valid <= 1'b0;
        send_event(make_evt(0, 0, 1, 0, 0, 1, 1, 1, 0, 1, 1));
        settle();

        // Sender mostly busy, receiver mostly stalled; pause halfway
        write_all(1'b1, 1'($urandom_range(1)), 1'b1, 8'($urandom), 8'($urandom),
                  8'($urandom));
        run_random(36, 1'b0, 1'b1);

        // Sender mostly idle, receiver mostly ready; X10
        tx_idle_pct = 85;
        rx_idle_pct = 7;
        write_all(1'b1, 1'b1, 1'b0, 8'h00, 8'hff, 8'h00);
        run_random(36, 1'b0, 1'b0);

        // No idling; long receiver hold-off to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_all(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom),
                  8'($urandom), 8'($urandom));
        run_random(36, 1'b1, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.expected_bytes.size() != 0) begin
            board.errors++;
            $display("%0t: %0d predicted bytes never arrived",
                     $time, board.expected_bytes.size());
        end
        if (board.errors == 0)
            $display("** mouse_report_encoder: PASSED **");
        else
            $display("** mouse_report_encoder: FAILED **");
        $finish;
    end
endmodule
